[hw/rtl/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// Shared command codes and the flag bundle of the shared subtract unit.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned CmdBits = 2;

  localparam logic [CmdBits-1:0] CMD_VALLEY = 2'd0;
  localparam logic [CmdBits-1:0] CMD_PEAK   = 2'd1;
  localparam logic [CmdBits-1:0] CMD_END    = 2'd2;

  // Compare flags for a - b, both taken as signed.
  typedef struct packed {
    logic lt;  // a < b
    logic le;  // a <= b
  } pps_flags_t;

endpackage

[hw/rtl/pps_ram.sv]
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/pps_alu.sv]
// ----------------------------------------------------------------------------
// pps_alu
// Shared signed subtractor with compare flags, one operation per cycle.
// ----------------------------------------------------------------------------
module pps_alu
  import pps_pkg::*;
#(
  parameter int unsigned W = 26
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] diff_o,
  output pps_flags_t   flags_o
);

  logic [W:0] wide;

  // One guard bit keeps the compare exact even when the difference wraps.
  assign wide          = {a_i[W-1], a_i} - {b_i[W-1], b_i};
  assign diff_o        = wide[W-1:0];
  assign flags_o.lt    = wide[W];
  assign flags_o.le    = wide[W] | (wide == '0);

endmodule

[hw/rtl/peak_prominence_stack_core.sv]
// ----------------------------------------------------------------------------
// peak_prominence_stack_core
// Streaming 1D topographic prominence over alternating valley and peak beats.
// ----------------------------------------------------------------------------
// Usage: input beats (cmd_i, position_i, height_i) arrive on in_valid_i /
// in_ready_o; result beats leave on out_valid_o / out_ready_i, each carrying
// one peak with its final prominence, last_o on the final beat caused by an
// input beat, and the sticky overflow_o flag. The base level for the first
// peak is written through cfg_we_i / cfg_wdata_i while the block is idle.
// Sequencing: one small sequencer drives a single shared subtract/compare unit.
// A valley beat takes a decode step, a first peak a decode step, a later
// peak a decode and a prominence step plus a top check, and each pop runs
// through base, top valley, drop compare, adjust, optional widening, emit,
// then the next top check or the flush. A peak that stops popping on a
// higher top then flushes its last held result. An end beat takes a decode
// step and a pop step per stacked peak, then flushes the last result, if any.
// The stack lives in a RAM with a registered read, so every top read is
// issued in the state before its use.
// The block accepts a new beat only while the sequencer is idle; a finished
// result may still sit in the output register then. If the receiver stalls,
// the sequencer holds the next result and waits. After reset the stack is
// empty, no peak is known, the base level is zero and overflow is clear.
// ----------------------------------------------------------------------------
module peak_prominence_stack_core
  import pps_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned HEIGHT_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration: base level of the first peak
  input  logic                   cfg_we_i,
  input  logic [HEIGHT_BITS-1:0] cfg_wdata_i,
  // Input beats
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CmdBits-1:0]     cmd_i,
  input  logic [31:0]            position_i,
  input  logic [HEIGHT_BITS-1:0] height_i,
  // Result beats
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [31:0]            peak_position_o,
  output logic [HEIGHT_BITS-1:0] peak_height_o,
  output logic [HEIGHT_BITS:0]   peak_prominence_o,
  output logic                   last_o,
  output logic                   overflow_o
);

  // Internal arithmetic carries two extra bits so that bases and
  // intermediate differences stay exact.
  localparam int unsigned W  = HEIGHT_BITS + 2;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RW = 32 + HEIGHT_BITS + W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_PROM   = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_BASE   = 4'd4;
  localparam logic [3:0] S_THP    = 4'd5;
  localparam logic [3:0] S_CMP    = 4'd6;
  localparam logic [3:0] S_ADJ    = 4'd7;
  localparam logic [3:0] S_WIDE   = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;
  localparam logic [3:0] S_FLUSH  = 4'd10;
  localparam logic [3:0] S_EPOP   = 4'd11;

  function automatic logic [W-1:0] sx(input logic [HEIGHT_BITS-1:0] v);
    sx = {{2{v[HEIGHT_BITS-1]}}, v};
  endfunction

  logic [3:0] state_q, state_d;

  // Control and stream state.
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   ref_valid_q, ref_valid_d;
  logic                   seen_q, seen_d;
  logic                   ovf_q, ovf_d;
  logic                   hold_v_q, hold_v_d;
  logic                   out_valid_q, out_valid_d;
  logic [HEIGHT_BITS-1:0] sea_q, sea_d;
  logic [31:0]            ref_pos_q, ref_pos_d;
  logic [HEIGHT_BITS-1:0] ref_h_q, ref_h_d;
  logic [W-1:0]           ref_prom_q, ref_prom_d;
  logic [W-1:0]           valley_q, valley_d;

  // Working registers.
  logic [CmdBits-1:0]     in_cmd_q, in_cmd_d;
  logic [31:0]            in_pos_q, in_pos_d;
  logic [HEIGHT_BITS-1:0] in_h_q, in_h_d;
  logic [31:0]            top_pos_q, top_pos_d;
  logic [HEIGHT_BITS-1:0] top_h_q, top_h_d;
  logic [W-1:0]           top_prom_q, top_prom_d;
  logic [W-1:0]           base_q, base_d;
  logic [W-1:0]           thp_q, thp_d;
  logic [W-1:0]           drop_q, drop_d;
  logic [31:0]            hold_pos_q, hold_pos_d;
  logic [HEIGHT_BITS-1:0] hold_h_q, hold_h_d;
  logic [W-1:0]           hold_prom_q, hold_prom_d;
  logic [31:0]            out_pos_q, out_pos_d;
  logic [HEIGHT_BITS-1:0] out_h_q, out_h_d;
  logic [HEIGHT_BITS:0]   out_prom_q, out_prom_d;
  logic                   out_last_q, out_last_d;
  logic                   out_ovf_q, out_ovf_d;

  // Shared unit and stack RAM hookup.
  logic [W-1:0]           alu_a, alu_b, alu_diff;
  pps_flags_t             alu_flags;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [RW-1:0]          ram_wdata, ram_rdata;
  logic [31:0]            rd_pos;
  logic [HEIGHT_BITS-1:0] rd_h;
  logic [W-1:0]           rd_prom;
  logic [CW-1:0]          cnt_m1, cnt_m2;
  logic                   slot_free;
  logic                   emit, emit_last;

  pps_alu #(
    .W (W)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .diff_o  (alu_diff),
    .flags_o (alu_flags)
  );

  pps_ram #(
    .WIDTH (RW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata = {ref_pos_q, ref_h_q, ref_prom_q};
  assign rd_pos    = ram_rdata[RW-1 -: 32];
  assign rd_h      = ram_rdata[W +: HEIGHT_BITS];
  assign rd_prom   = ram_rdata[W-1:0];

  assign cnt_m1    = cnt_q - CW'(1);
  assign cnt_m2    = cnt_q - CW'(2);
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ref_valid_d = ref_valid_q;
    seen_d      = seen_q;
    ovf_d       = ovf_q;
    hold_v_d    = hold_v_q;
    sea_d       = cfg_we_i ? cfg_wdata_i : sea_q;
    ref_pos_d   = ref_pos_q;
    ref_h_d     = ref_h_q;
    ref_prom_d  = ref_prom_q;
    valley_d    = valley_q;
    in_cmd_d    = in_cmd_q;
    in_pos_d    = in_pos_q;
    in_h_d      = in_h_q;
    top_pos_d   = top_pos_q;
    top_h_d     = top_h_q;
    top_prom_d  = top_prom_q;
    base_d      = base_q;
    thp_d       = thp_q;
    drop_d      = drop_q;
    hold_pos_d  = hold_pos_q;
    hold_h_d    = hold_h_q;
    hold_prom_d = hold_prom_q;
    alu_a       = '0;
    alu_b       = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = cnt_m1[AW-1:0];
    emit        = 1'b0;
    emit_last   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_cmd_d = cmd_i;
          in_pos_d = position_i;
          in_h_d   = height_i;
          state_d  = S_DECODE;
        end
      end

      S_DECODE: begin
        case (in_cmd_q)
          CMD_VALLEY: begin
            // Keep the lowest valley since the last peak.
            alu_a = sx(in_h_q);
            alu_b = valley_q;
            if (ref_valid_q && (!seen_q || alu_flags.lt)) begin
              valley_d = sx(in_h_q);
              seen_d   = 1'b1;
            end
            state_d = S_IDLE;
          end
          CMD_PEAK: begin
            if (!ref_valid_q) begin
              alu_a       = sx(in_h_q);
              alu_b       = sx(sea_q);
              ref_pos_d   = in_pos_q;
              ref_h_d     = in_h_q;
              ref_prom_d  = alu_diff;
              ref_valid_d = 1'b1;
              seen_d      = 1'b0;
              state_d     = S_IDLE;
            end else begin
              // Without a valley, the lower of the two peaks stands in.
              alu_a = sx(ref_h_q);
              alu_b = sx(in_h_q);
              if (!seen_q) begin
                valley_d = alu_flags.lt ? sx(ref_h_q) : sx(in_h_q);
              end
              if (cnt_q < CW'(STACK_DEPTH)) begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
              ref_pos_d = in_pos_q;
              ref_h_d   = in_h_q;
              seen_d    = 1'b0;
              state_d   = S_PROM;
            end
          end
          CMD_END: begin
            if (ref_valid_q) begin
              hold_pos_d  = ref_pos_q;
              hold_h_d    = ref_h_q;
              hold_prom_d = ref_prom_q;
              hold_v_d    = 1'b1;
            end
            ref_pos_d   = '0;
            ref_h_d     = '0;
            ref_prom_d  = '0;
            ref_valid_d = 1'b0;
            valley_d    = '0;
            seen_d      = 1'b0;
            if (cnt_q != '0) begin
              ram_re  = 1'b1;
              state_d = S_EPOP;
            end else begin
              state_d = ref_valid_q ? S_FLUSH : S_IDLE;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_PROM: begin
        alu_a      = sx(ref_h_q);
        alu_b      = valley_q;
        ref_prom_d = alu_diff;
        if (cnt_q != '0) begin
          ram_re  = 1'b1;
          state_d = S_CHK;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_CHK: begin
        // Pop while the stack top is not higher than the reference.
        alu_a = sx(rd_h);
        alu_b = sx(ref_h_q);
        if (alu_flags.le) begin
          top_pos_d  = rd_pos;
          top_h_d    = rd_h;
          top_prom_d = rd_prom;
          state_d    = S_BASE;
        end else begin
          state_d = hold_v_q ? S_FLUSH : S_IDLE;
        end
      end

      S_BASE: begin
        alu_a   = sx(ref_h_q);
        alu_b   = ref_prom_q;
        base_d  = alu_diff;
        state_d = S_THP;
      end

      S_THP: begin
        alu_a   = sx(top_h_q);
        alu_b   = top_prom_q;
        thp_d   = alu_diff;
        state_d = S_CMP;
      end

      S_CMP: begin
        alu_a   = sx(top_h_q);
        alu_b   = base_q;
        drop_d  = alu_diff;
        state_d = S_ADJ;
      end

      S_ADJ: begin
        // A popped peak reaching below the reference's base is cut back.
        alu_a = drop_q;
        alu_b = top_prom_q;
        if (alu_flags.lt) begin
          top_prom_d = drop_q;
          state_d    = S_WIDE;
        end else begin
          state_d = S_EMIT;
        end
      end

      S_WIDE: begin
        alu_a      = sx(ref_h_q);
        alu_b      = thp_q;
        ref_prom_d = alu_diff;
        state_d    = S_EMIT;
      end

      S_EMIT: begin
        if (!hold_v_q || slot_free) begin
          emit        = hold_v_q;
          hold_pos_d  = top_pos_q;
          hold_h_d    = top_h_q;
          hold_prom_d = top_prom_q;
          hold_v_d    = 1'b1;
          cnt_d       = cnt_m1;
          if (cnt_m1 != '0) begin
            ram_re    = 1'b1;
            ram_raddr = cnt_m2[AW-1:0];
            state_d   = S_CHK;
          end else begin
            state_d = S_FLUSH;
          end
        end
      end

      S_EPOP: begin
        if (!hold_v_q || slot_free) begin
          emit        = hold_v_q;
          hold_pos_d  = rd_pos;
          hold_h_d    = rd_h;
          hold_prom_d = rd_prom;
          hold_v_d    = 1'b1;
          cnt_d       = cnt_m1;
          if (cnt_m1 != '0) begin
            ram_re    = 1'b1;
            ram_raddr = cnt_m2[AW-1:0];
          end else begin
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          hold_v_d  = 1'b0;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: loaded from the held result when it is released.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_pos_d   = out_pos_q;
    out_h_d     = out_h_q;
    out_prom_d  = out_prom_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_pos_d   = hold_pos_q;
      out_h_d     = hold_h_q;
      out_prom_d  = hold_prom_q[HEIGHT_BITS:0];
      out_last_d  = emit_last;
      out_ovf_d   = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ref_valid_q <= 1'b0;
      seen_q      <= 1'b0;
      ovf_q       <= 1'b0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      sea_q       <= '0;
      ref_pos_q   <= '0;
      ref_h_q     <= '0;
      ref_prom_q  <= '0;
      valley_q    <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ref_valid_q <= ref_valid_d;
      seen_q      <= seen_d;
      ovf_q       <= ovf_d;
      hold_v_q    <= hold_v_d;
      out_valid_q <= out_valid_d;
      sea_q       <= sea_d;
      ref_pos_q   <= ref_pos_d;
      ref_h_q     <= ref_h_d;
      ref_prom_q  <= ref_prom_d;
      valley_q    <= valley_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_cmd_q    <= in_cmd_d;
    in_pos_q    <= in_pos_d;
    in_h_q      <= in_h_d;
    top_pos_q   <= top_pos_d;
    top_h_q     <= top_h_d;
    top_prom_q  <= top_prom_d;
    base_q      <= base_d;
    thp_q       <= thp_d;
    drop_q      <= drop_d;
    hold_pos_q  <= hold_pos_d;
    hold_h_q    <= hold_h_d;
    hold_prom_q <= hold_prom_d;
    out_pos_q   <= out_pos_d;
    out_h_q     <= out_h_d;
    out_prom_q  <= out_prom_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o       = out_valid_q;
  assign peak_position_o   = out_pos_q;
  assign peak_height_o     = out_h_q;
  assign peak_prominence_o = out_prom_q;
  assign last_o            = out_last_q;
  assign overflow_o        = out_ovf_q;

endmodule
